// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0]  CH_SPACE   = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_FG   = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG   = 4'h0;

    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 8'd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_SCROLL,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
    } result_t;

    function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] bg,
                                                     input logic [COLOR_W-1:0] fg,
                                                     input logic [CHAR_W-1:0]  ch);
        return {bg, fg, ch};
    endfunction

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Screen cell store: one write port, one registered read port.
module tcw_ram
    import tcw_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Sequencer: cursor state, shared address counter for sweeps and scroll copy, and reads.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [POS_W-1:0]   cell_address,
    input  logic [COLOR_W-1:0] fg,
    input  logic [COLOR_W-1:0] bg,
    output result_t            res,
    input  logic               res_ready,
    output mem_req_t           mem,
    input  logic [CELL_W-1:0]  mem_rdata
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [CELL_W-1:0] fill_reg, fill_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CELL_W-1:0] data_reg, data_next;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] cnt_plus;
    logic              ordinary;
    logic              wrap;
    logic              accept;

    assign cur_addr = base_reg + ADDR_W'(col_reg);
    assign cnt_plus = cnt_reg + ADDR_W'(1);
    assign ordinary = (char_code != CH_NEWLINE) && (char_code != CH_RETURN);
    assign wrap     = (ordinary && (col_reg == COL_W'(COLUMNS - 1)))
                      || (char_code == CH_NEWLINE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            base_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wr_pend_reg <= wr_pend_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            base_reg    <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        fill_reg    <= fill_next;
        data_reg    <= data_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = 1'b0;
        fill_next    = fill_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        base_next    = base_reg;
        data_next    = data_reg;
        in_ready     = 1'b0;
        mem.we       = 1'b0;
        mem.waddr    = cnt_reg;
        mem.wdata    = fill_reg;
        mem.raddr    = cnt_plus;
        res.valid    = 1'b0;
        res.pos      = POS_W'(cur_addr);
        res.data     = data_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                mem.we    = 1'b1;
                mem.wdata = make_cell(RESET_BG, RESET_FG, CH_SPACE);
                cnt_next  = cnt_plus;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem.raddr = ADDR_W'(cell_address);
                if (accept)
                begin
                    data_next  = '0;
                    fill_next  = make_cell(bg, fg, CH_SPACE);
                    state_next = ST_DONE;
                    unique case (func)
                        FUNC_PUT:
                        begin
                            mem.we    = ordinary;
                            mem.waddr = cur_addr;
                            mem.wdata = make_cell(bg, fg, char_code);
                            col_next  = (ordinary && !wrap) ? col_reg + COL_W'(1) : '0;
                            if (wrap)
                            begin
                                if (row_reg == ROW_W'(ROWS - 1))
                                begin
                                    cnt_next   = '0;
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next  = row_reg + ROW_W'(1);
                                    base_next = base_reg + ADDR_W'(COLUMNS);
                                end
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            base_next  = '0;
                            cnt_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        FUNC_READ:
                        begin
                            if (32'(cell_address) < CELL_COUNT)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                mem.we   = 1'b1;
                cnt_next = cnt_plus;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            // row move: read cell cnt+COLUMNS, write it to cnt in the next cycle
            ST_SCROLL:
            begin
                mem.we    = wr_pend_reg;
                mem.waddr = wr_addr_reg;
                mem.wdata = mem_rdata;
                mem.raddr = cnt_reg + ADDR_W'(COLUMNS);
                if (cnt_reg == ADDR_W'(CELL_COUNT - COLUMNS))
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    wr_pend_next = 1'b1;
                    wr_addr_next = cnt_reg;
                    cnt_next     = cnt_plus;
                end
            end

            ST_READ:
            begin
                data_next  = mem_rdata;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Text console writer top level: stream ports, color registers, output register.
// Clear sweeps every cell with the current colors; a scroll copies each row up and then
// blanks the last row. Both are paced by one address counter and the single write port
// of the cell store.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: a clearing pass over all CELL_COUNT (2000) cells blanks the store; no request taken.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // char_code[7:0], cell_address[18:8], zero pad
    input  logic [FUNC_W-1:0]    s_tuser,   // func[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // cursor_position[10:0], cell_data[26:11], zero pad
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [CELL_W-1:0]  out_data_reg;
    logic               res_ready;
    result_t            res;
    mem_req_t           mem;
    logic [CELL_W-1:0]  mem_rdata;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_data_reg, out_pos_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FOREGROUND)
            begin
                fg_reg <= cfg_data;
            end
            if (cfg_index == REG_BACKGROUND)
            begin
                bg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            out_pos_reg  <= res.pos;
            out_data_reg <= res.data;
        end
    end

    tcw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .func         (s_tuser),
        .char_code    (s_tdata[7:0]),
        .cell_address (s_tdata[18:8]),
        .fg           (fg_reg),
        .bg           (bg_reg),
        .res          (res),
        .res_ready    (res_ready),
        .mem          (mem),
        .mem_rdata    (mem_rdata)
    );

    tcw_ram u_ram (
        .clk   (clk),
        .req   (mem),
        .rdata (mem_rdata)
    );

endmodule
